[src/assert_macros.svh]
// Assertion macros used by the checker module.
// Standalone header; users include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds -> c holds in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("implication check failed");

// a holds -> c holds in the next cycle
`define ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");

`endif

[src/slhs_pkg.sv]
// Package for the spike lag history store: widths, codes, row and state types.
// No dependencies.
`timescale 1ns / 1ps

package slhs_pkg;

   localparam int NEURONS  = 4096;
   localparam int LAGS     = 8;

   localparam int AGE_W    = 15;
   localparam int OP_W     = 2;
   localparam int NEURON_W = 12;
   localparam int HELD_W   = 4;
   localparam int ADDR_W   = (NEURONS > 1) ? $clog2(NEURONS) : 1;
   localparam int SLOT_W   = (LAGS > 1) ? $clog2(LAGS) : 1;
   localparam int CNT_W    = $clog2(LAGS + 1);

   localparam int REQ_DATA_W = ((NEURON_W + 7) / 8) * 8;
   localparam int RSP_BITS   = AGE_W + HELD_W + 2;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [AGE_W-1:0] AGE_EMPTY     = AGE_W'(32767);
   localparam logic [AGE_W-1:0] MAX_LAG_RESET = AGE_W'(100);

   typedef enum logic [OP_W-1:0] {
      OP_AGE   = 2'd0,
      OP_SPIKE = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RMW
   } state_type;

   typedef struct packed {
      logic [CNT_W-1:0]                count;
      logic [LAGS-1:0][AGE_W-1:0]      ages;
   } row_type;

   typedef struct packed {
      logic              dropped;
      logic              expired;
      logic [HELD_W-1:0] held_count;
      logic [AGE_W-1:0]  newest_lag;
   } rsp_type;

endpackage

[src/slhs_ram.sv]
// Generic single-clock RAM, one write port and one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module slhs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/spike_lag_history_store_core.sv]
// Per-neuron spike age queues held as one row per neuron in a row memory.
// Depends on slhs_pkg and slhs_ram.
`timescale 1ns / 1ps
// Response: a req transfer moves the core to ST_RMW, where the row read returns;
//   rsp_tvalid is registered as the row is written, held off while a response
//   waits. Requests go one at a time on the single row memory (ST_RMW blocks).
// Reset: clearing pass over all 4096 rows of the row memory (req_tready low),
//   max_lag returns to 100; csr writes are taken during the pass.

module spike_lag_history_store_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [slhs_pkg::REQ_DATA_W-1:0]       req_tdata,  // neuron, zero pad
   input  logic [slhs_pkg::OP_W-1:0]             req_tuser,  // operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // newest_lag, held_count, expired, dropped, zero pad
   output logic [slhs_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_wr_en,
   input  logic [slhs_pkg::AGE_W-1:0]            csr_wr_data
);

   import slhs_pkg::*;

   state_type           state_ff, state_in;
   logic [AGE_W-1:0]    max_lag_ff;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   op_type              op_ff;
   logic [NEURON_W-1:0] neuron_ff;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_xfer;
   logic                rmw_fire;
   logic                in_range;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   row_type             wr_row;
   row_type             rd_row;
   row_type             new_row;

   logic [CNT_W-1:0]    cnt_old, cnt_new, cnt_m1;
   logic [AGE_W-1:0]    thr;
   logic                expired, dropped;
   logic [LAGS-1:0][AGE_W-1:0] shifted, aged;
   logic [AGE_W-1:0]    newest;

   assign req_xfer = req_tvalid && req_tready;
   assign rmw_fire = (state_ff == ST_RMW) && (!rsp_tvalid_ff || rsp_tready);
   assign in_range = {1'b0, neuron_ff} < (NEURON_W + 1)'(NEURONS);

   slhs_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (NEURONS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row),
      .rd_en   (req_xfer),
      .rd_addr (req_tdata[ADDR_W-1:0]),
      .rd_data (rd_row)
   );

   // row update
   always_comb begin
      cnt_old = (rd_row.count > CNT_W'(LAGS)) ? CNT_W'(LAGS) : rd_row.count;
      thr     = max_lag_ff - AGE_W'(1);
      expired = 1'b0;
      dropped = 1'b0;
      cnt_new = cnt_old;
      shifted = rd_row.ages;
      aged    = rd_row.ages;
      new_row = rd_row;
      unique case (op_ff)
         OP_AGE: begin
            expired = (cnt_old != '0) && (rd_row.ages[0] == thr);
            if (expired) begin
               cnt_new = cnt_old - CNT_W'(1);
               for (int i = 0; i < LAGS - 1; i++) begin
                  shifted[i] = rd_row.ages[i+1];
               end
            end
            for (int i = 0; i < LAGS; i++) begin
               aged[i] = (shifted[i] < AGE_EMPTY) ? shifted[i] + AGE_W'(1) : shifted[i];
            end
            new_row.ages = aged;
         end
         OP_SPIKE: begin
            if (cnt_old < CNT_W'(LAGS)) begin
               cnt_new = cnt_old + CNT_W'(1);
               for (int i = 0; i < LAGS; i++) begin
                  if (CNT_W'(i) == cnt_old) begin
                     new_row.ages[i] = AGE_W'(1);
                  end
               end
            end else begin
               dropped = 1'b1;
            end
         end
         OP_QUERY, OP_NONE: begin
         end
         default: begin
         end
      endcase
      new_row.count = cnt_new;
      cnt_m1 = cnt_new - CNT_W'(1);
      newest = (cnt_new == '0) ? AGE_EMPTY : new_row.ages[cnt_m1[SLOT_W-1:0]];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_addr_ff == ADDR_W'(NEURONS - 1)) state_in = ST_IDLE;
         ST_IDLE:  if (req_xfer) state_in = ST_RMW;
         ST_RMW:   if (rmw_fire) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   // outputs and datapath controls
   always_comb begin
      req_tready    = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = neuron_ff[ADDR_W-1:0];
      wr_row        = new_row;
      clr_addr_in   = clr_addr_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_addr_ff;
            wr_row      = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            req_tready = 1'b1;
         end
         ST_RMW: begin
            if (rmw_fire) begin
               wr_en         = in_range;
               rsp_tvalid_in = 1'b1;
               if (in_range) begin
                  rsp_in.newest_lag = newest;
                  rsp_in.held_count = HELD_W'(cnt_new);
                  rsp_in.expired    = expired;
                  rsp_in.dropped    = dropped;
               end else begin
                  rsp_in = '{dropped: 1'b0, expired: 1'b0, held_count: '0,
                             newest_lag: AGE_EMPTY};
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_tvalid_ff <= 1'b0;
         max_lag_ff    <= MAX_LAG_RESET;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_wr_en) begin
            max_lag_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (req_xfer) begin
         op_ff     <= op_type'(req_tuser);
         neuron_ff <= req_tdata[NEURON_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_ff);

endmodule

[src/slhs_checker.sv]
// Port-level checks for spike_lag_history_store_core, bound to the top level.
// Depends on slhs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slhs_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [slhs_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [slhs_pkg::OP_W-1:0]       req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [slhs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_wr_en,
   input logic [slhs_pkg::AGE_W-1:0]      csr_wr_data
);

   import slhs_pkg::*;

   logic [AGE_W-1:0]  newest;
   logic [HELD_W-1:0] held;
   logic              expired;
   logic              dropped;

   assign newest  = rsp_tdata[AGE_W-1:0];
   assign held    = rsp_tdata[AGE_W+HELD_W-1:AGE_W];
   assign expired = rsp_tdata[AGE_W+HELD_W];
   assign dropped = rsp_tdata[AGE_W+HELD_W+1];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_tvalid && req_tready, !req_tready)
   `ASSERT_IMPLIES(a_held_range, clock, reset, rsp_tvalid, held <= HELD_W'(LAGS))
   `ASSERT_IMPLIES(a_flags_excl, clock, reset, rsp_tvalid, !(expired && dropped))
   `ASSERT_IMPLIES(a_empty_lag, clock, reset, rsp_tvalid && (held == '0), newest == AGE_EMPTY)

endmodule

bind spike_lag_history_store_core slhs_checker u_slhs_checker (.*);

[sim/spike_lag_history_store_core_tb.sv]
// Testbench for spike_lag_history_store_core: directed and random phases.
// Checks every response against its own per-neuron lag queue predictor.
// Depends on slhs_pkg and the core RTL.
`timescale 1ns / 1ps

module spike_lag_history_store_core_tb;
   import slhs_pkg::*;

   typedef struct {
      op_type                op;
      logic [NEURON_W-1:0]   neuron;
   } lag_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_wr_en   = 1'b0;
   logic [AGE_W-1:0]        csr_wr_data = '0;

   spike_lag_history_store_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [AGE_W-1:0] lag_rows [NEURONS][LAGS];
   int               held_rows [NEURONS];
   logic [AGE_W-1:0] lag_cap = MAX_LAG_RESET;

   lag_cmd_type lag_cmds_waiting [$];
   rsp_type     lag_results_due [$];
   lag_cmd_type on_bus;

   int      req_gap = 0;
   int      rsp_stall = 0;
   bit      quiet = 1'b0;
   int      mismatch_count = 0;
   int      transfers_checked = 0;
   int      expiries_seen = 0;
   int      drops_seen = 0;
   int      cap_settings = 1;
   rsp_type seen_rsp, due_rsp;

   initial begin
      for (int n = 0; n < NEURONS; n++) held_rows[n] = 0;
   end

   function automatic rsp_type apply_lag_op(op_type op, logic [NEURON_W-1:0] n);
      rsp_type          r;
      int               c;
      logic [AGE_W-1:0] thr;
      r   = '0;
      c   = held_rows[n];
      thr = lag_cap - 1'b1;
      if (op == OP_AGE) begin
         if (c > 0 && lag_rows[n][0] == thr) begin
            for (int i = 1; i < c; i++) lag_rows[n][i-1] = lag_rows[n][i];
            c--;
            r.expired = 1'b1;
         end
         for (int i = 0; i < c; i++)
            if (lag_rows[n][i] != AGE_EMPTY) lag_rows[n][i] = lag_rows[n][i] + 1'b1;
      end else if (op == OP_SPIKE) begin
         if (c < LAGS) begin
            lag_rows[n][c] = AGE_W'(1);
            c++;
         end else begin
            r.dropped = 1'b1;
         end
      end
      held_rows[n] = c;
      r.newest_lag = (c == 0) ? AGE_EMPTY : lag_rows[n][c-1];
      r.held_count = HELD_W'(c);
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            lag_results_due.push_back(apply_lag_op(on_bus.op, on_bus.neuron));
         if (req_gap > 0) begin
            req_gap    <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            req_gap    <= $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else if (lag_cmds_waiting.size() > 0) begin
            on_bus     <= lag_cmds_waiting[0];
            req_tdata  <= REQ_DATA_W'(lag_cmds_waiting[0].neuron);
            req_tuser  <= lag_cmds_waiting[0].op;
            req_tvalid <= 1'b1;
            void'(lag_cmds_waiting.pop_front());
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen_rsp = rsp_tdata[RSP_BITS-1:0];
            if (lag_results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: response with none pending, actual %h", $time, seen_rsp);
            end else begin
               due_rsp = lag_results_due.pop_front();
               transfers_checked++;
               if (seen_rsp.expired) expiries_seen++;
               if (seen_rsp.dropped) drops_seen++;
               if (seen_rsp.newest_lag !== due_rsp.newest_lag) begin
                  mismatch_count++;
                  $display("%0t: newest_lag expected %0d actual %0d", $time,
                           due_rsp.newest_lag, seen_rsp.newest_lag);
               end
               if (seen_rsp.held_count !== due_rsp.held_count) begin
                  mismatch_count++;
                  $display("%0t: held_count expected %0d actual %0d", $time,
                           due_rsp.held_count, seen_rsp.held_count);
               end
               if (seen_rsp.expired !== due_rsp.expired) begin
                  mismatch_count++;
                  $display("%0t: expired expected %0b actual %0b", $time,
                           due_rsp.expired, seen_rsp.expired);
               end
               if (seen_rsp.dropped !== due_rsp.dropped) begin
                  mismatch_count++;
                  $display("%0t: dropped expected %0b actual %0b", $time,
                           due_rsp.dropped, seen_rsp.dropped);
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_stall  <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic queue_cmd(op_type op, logic [NEURON_W-1:0] n);
      lag_cmd_type c;
      c.op     = op;
      c.neuron = n;
      lag_cmds_waiting.push_back(c);
   endtask

   // hold off until every transfer is answered; leaves the caller at a falling edge
   task automatic wait_drained();
      do @(negedge clock);
      while (lag_cmds_waiting.size() != 0 || req_tvalid || lag_results_due.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_lag_cap(logic [AGE_W-1:0] v);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      lag_cap     <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      cap_settings++;
      @(negedge clock);
   endtask

   task automatic age_run(logic [NEURON_W-1:0] n, int count);
      for (int i = 0; i < count; i++) queue_cmd(OP_AGE, n);
   endtask

   task automatic random_phase(logic [AGE_W-1:0] cap, int items);
      logic [NEURON_W-1:0] pool [6];
      int                  age_w;
      int                  r;
      logic [NEURON_W-1:0] n;
      write_lag_cap(cap);
      pool[0] = '0;
      pool[1] = '1;
      for (int i = 2; i < 6; i++) pool[i] = NEURON_W'($urandom_range(0, NEURONS - 1));
      age_w = $urandom_range(30, 60);
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if ($urandom_range(0, 9) == 0) n = NEURON_W'($urandom_range(0, NEURONS - 1));
         else n = pool[$urandom_range(0, 5)];
         if (r < age_w) queue_cmd(OP_AGE, n);
         else if (r < age_w + 35) queue_cmd(OP_SPIKE, n);
         else if (r[0]) queue_cmd(OP_QUERY, n);
         else queue_cmd(OP_NONE, n);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty queue, unused code, full queue at the top neuron
      queue_cmd(OP_QUERY, '0);
      queue_cmd(OP_NONE, '0);
      queue_cmd(OP_AGE, '0);
      for (int i = 0; i < LAGS + 1; i++) queue_cmd(OP_SPIKE, '1);
      queue_cmd(OP_QUERY, '1);
      queue_cmd(OP_AGE, '1);
      queue_cmd(OP_NONE, '1);
      queue_cmd(OP_SPIKE, 12'hA5A);

      // smallest legal cap, then stranded ages after expiry threshold passed
      write_lag_cap(AGE_W'(2));
      queue_cmd(OP_SPIKE, '0);
      queue_cmd(OP_AGE, '0);
      queue_cmd(OP_SPIKE, '0);
      queue_cmd(OP_SPIKE, '0);
      queue_cmd(OP_AGE, '0);
      queue_cmd(OP_AGE, '0);
      queue_cmd(OP_QUERY, '0);

      // cap of one never expires; cap of zero wraps the threshold to the top age
      write_lag_cap(AGE_W'(1));
      queue_cmd(OP_SPIKE, 12'h123);
      queue_cmd(OP_AGE, 12'h123);
      queue_cmd(OP_SPIKE, 12'h123);
      age_run(12'h123, 6);
      write_lag_cap(AGE_W'(32767));
      queue_cmd(OP_AGE, 12'h123);
      write_lag_cap(AGE_W'(1));
      age_run(12'h123, 2);
      queue_cmd(OP_QUERY, 12'h123);
      write_lag_cap(AGE_W'(0));
      queue_cmd(OP_AGE, 12'h123);

      random_phase(AGE_W'(2), 220);
      random_phase(AGE_W'(3), 220);
      random_phase(AGE_W'(5), 220);
      random_phase(AGE_W'(9), 220);
      random_phase(MAX_LAG_RESET, 200);
      random_phase(AGE_W'(32767), 200);
      random_phase(AGE_W'($urandom_range(2, 32767)), 200);
      random_phase(AGE_W'($urandom_range(2, 20)), 250);
      wait_drained();
      quiet = 1'b1;
      random_phase(AGE_W'(4), 250);

      wait_drained();
      repeat (10) @(negedge clock);
      if (lag_results_due.size() != 0) begin
         mismatch_count++;
         $display("%0t: %0d responses never arrived", $time, lag_results_due.size());
      end
      $display("checked %0d responses over %0d max_lag settings", transfers_checked,
               cap_settings);
      $display("saw %0d expiries and %0d refused spikes", expiries_seen, drops_seen);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #8_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
